// File: hw/rtl/mmrs_pkg.sv
// Shared types, codes and helpers of the masked register store.
`default_nettype none

package mmrs_pkg;

  localparam int NumRegsDef = 16;

  localparam logic [2:0] OP_DEFINE = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_POKE   = 3'd3;
  localparam logic [2:0] OP_CHECK  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_MISALIGNED = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  // lookup targets of the slot table
  localparam int NumTgt    = 4;
  localparam int TGT_FULL  = 0;
  localparam int TGT_WORD  = 1;
  localparam int TGT_DWORD = 2;
  localparam int TGT_NEXT  = 3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_HIGH = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_DEFINE,
    KIND_RD_DW,
    KIND_WR_DW,
    KIND_RD_SUB,
    KIND_WR_SUB,
    KIND_POKE
  } kind_e;

  function automatic logic [63:0] lane_bits(input logic [3:0] size);
    logic [63:0] lanes;
    case (size)
      4'd1:    lanes = 64'h0000_0000_0000_00ff;
      4'd2:    lanes = 64'h0000_0000_0000_ffff;
      4'd4:    lanes = 64'h0000_0000_ffff_ffff;
      default: lanes = 64'hffff_ffff_ffff_ffff;
    endcase
    return lanes;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mmrs_mem.sv
// Two-read, one-write synchronous memory with registered read data.
`default_nettype none

module mmrs_mem #(
  parameter int Depth = 16,
  parameter int Width = 64,
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [IdxW-1:0]  raddr_a_i,
  input  wire logic [IdxW-1:0]  raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mmrs_cam.sv
// Slot address table with parallel lookup and free-slot search.
`default_nettype none

module mmrs_cam
  import mmrs_pkg::*;
#(
  parameter int NUM_REGS = NumRegsDef,
  localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [63:0]                    addr_i,
  input  wire logic                           upd_en_i,
  input  wire logic [IdxW-1:0]                upd_idx_i,
  input  wire logic [63:0]                    upd_addr_i,
  input  wire logic                           upd_word_i,
  output logic      [NumTgt-1:0]              hit_o,
  output logic      [NumTgt-1:0][IdxW-1:0]    idx_o,
  output logic                                full_word_o,
  output logic                                free_hit_o,
  output logic      [IdxW-1:0]                free_idx_o
);

  logic [NUM_REGS-1:0] valid_q;
  logic [NUM_REGS-1:0] word_q;
  logic [63:0]         addr_q [NUM_REGS];
  logic [63:0]         tgt [NumTgt];

  assign tgt[TGT_FULL]  = addr_i;
  assign tgt[TGT_WORD]  = {addr_i[63:2], 2'b00};
  assign tgt[TGT_DWORD] = {addr_i[63:3], 3'b000};
  assign tgt[TGT_NEXT]  = addr_i + 64'd4;

  // lowest matching slot wins
  always_comb begin
    hit_o       = '0;
    idx_o       = '0;
    full_word_o = 1'b0;
    free_hit_o  = 1'b0;
    free_idx_o  = '0;
    for (int t = 0; t < NumTgt; t++) begin
      for (int k = NUM_REGS - 1; k >= 0; k--) begin
        if (valid_q[k] && (addr_q[k] == tgt[t])) begin
          hit_o[t] = 1'b1;
          idx_o[t] = IdxW'(k);
          if (t == TGT_FULL) begin
            full_word_o = word_q[k];
          end
        end
      end
    end
    for (int k = NUM_REGS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_hit_o = 1'b1;
        free_idx_o = IdxW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (upd_en_i) begin
      valid_q[upd_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      addr_q[upd_idx_i] <= upd_addr_i;
      word_q[upd_idx_i] <= upd_word_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/masked_mmio_register_store.sv
// Top level: item sequencer, slot table and value/mask memories.
//
//   channel   direction  handshake                 payload
//   command   in         start_i, busy_o           opcode_i address_i size_bytes_i
//                                                   write_data_i write_mask_i
//   result    out        result_valid_o (strobe)   status_o read_data_o
//
// An item is taken when start_i is high and busy_o is low. It goes through lookup
// (slot table compare, memory read) and then execute (modify, write back); busy_o
// is low again in the execute cycle unless an upper write is due, so the next item
// can be taken during execute. A doubleword write to a word entry whose upper
// neighbour exists adds S_HIGH for the second write through the single memory write port.
// The result strobe is high for one cycle, the cycle after execute.
// Reset clears the slot valid bits at once; no clearing pass is needed.
`default_nettype none

module masked_mmio_register_store
  import mmrs_pkg::*;
#(
  parameter int NUM_REGS = NumRegsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [63:0] address_i,
  input  wire logic [3:0]  size_bytes_i,
  input  wire logic [63:0] write_data_i,
  input  wire logic [63:0] write_mask_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [63:0]      read_data_o
);

  localparam int IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef struct packed {
    logic [2:0]      status;
    kind_e           kind;
    logic [IdxW-1:0] idx_a;
    logic [IdxW-1:0] idx_b;
    logic            b_ok;
    logic            a_word;
    logic [2:0]      off;
  } ctx_t;

  state_e state_q, state_d;
  ctx_t   ctx_q, ctx_d;

  logic [2:0]  op_q;
  logic [63:0] addr_q, data_q, wmask_q;
  logic [3:0]  size_q;
  logic        accept;

  logic [NumTgt-1:0]           hit;
  logic [NumTgt-1:0][IdxW-1:0] idx;
  logic                        full_word;
  logic                        free_hit;
  logic [IdxW-1:0]             free_idx;

  logic [63:0] va, vb, ma, mb;
  logic        need_high;
  logic        upd_en;

  logic [63:0] hi_val_q, hi_val_d;
  logic        result_valid_q;
  logic [2:0]  status_q;
  logic [63:0] rdata_q, rdata_d;

  logic            val_we;
  logic [IdxW-1:0] val_waddr;
  logic [63:0]     val_wdata;
  logic [63:0]     new_a;
  logic            wa_en;

  assign need_high = (ctx_q.kind == KIND_WR_DW) && ctx_q.b_ok;
  assign busy_o    = (state_q == S_LOOK) || ((state_q == S_EXEC) && need_high);
  assign accept    = start_i && !busy_o;

  // hold the item while it is worked on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      addr_q  <= address_i;
      size_q  <= size_bytes_i;
      data_q  <= write_data_i;
      wmask_q <= write_mask_i;
    end
  end

  mmrs_cam #(
    .NUM_REGS (NUM_REGS)
  ) u_cam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .addr_i      (addr_q),
    .upd_en_i    (upd_en),
    .upd_idx_i   (ctx_q.idx_a),
    .upd_addr_i  (addr_q),
    .upd_word_i  (size_q == 4'd4),
    .hit_o       (hit),
    .idx_o       (idx),
    .full_word_o (full_word),
    .free_hit_o  (free_hit),
    .free_idx_o  (free_idx)
  );

  // lookup decode
  logic [3:0]      size_m1;
  logic            mis;
  logic            size_ok;
  logic            sub_hit;
  logic [IdxW-1:0] sub_idx;
  logic [2:0]      sub_off;

  always_comb begin
    size_m1 = size_q - 4'd1;
    mis     = (addr_q[2:0] & size_m1[2:0]) != 3'b000;
    size_ok = size_q inside {4'd1, 4'd2, 4'd4, 4'd8};
    sub_hit = 1'b1;
    sub_idx = idx[TGT_WORD];
    sub_off = {1'b0, addr_q[1:0]};
    if (!hit[TGT_WORD]) begin
      sub_hit = hit[TGT_DWORD];
      sub_idx = idx[TGT_DWORD];
      sub_off = addr_q[2:0];
    end

    ctx_d        = '0;
    ctx_d.status = ST_OK;
    ctx_d.kind   = KIND_NONE;
    ctx_d.idx_a  = idx[TGT_FULL];
    ctx_d.idx_b  = idx[TGT_NEXT];
    case (op_q)
      OP_DEFINE: begin
        if (!(size_q inside {4'd4, 4'd8})) begin
          ctx_d.status = ST_BAD_SIZE;
        end else if (mis) begin
          ctx_d.status = ST_MISALIGNED;
        end else if (hit[TGT_FULL]) begin
          ctx_d.kind = KIND_DEFINE;
        end else if (free_hit) begin
          ctx_d.kind  = KIND_DEFINE;
          ctx_d.idx_a = free_idx;
        end else begin
          ctx_d.status = ST_FULL;
        end
      end
      OP_READ, OP_WRITE, OP_CHECK: begin
        if (!size_ok) begin
          ctx_d.status = ST_BAD_SIZE;
        end else if (mis) begin
          ctx_d.status = ST_MISALIGNED;
        end else if ((size_q == 4'd8) && (op_q != OP_CHECK)) begin
          if (!hit[TGT_FULL]) begin
            ctx_d.status = ST_NOT_FOUND;
          end else begin
            ctx_d.kind   = (op_q == OP_READ) ? KIND_RD_DW : KIND_WR_DW;
            ctx_d.a_word = full_word;
            ctx_d.b_ok   = full_word && hit[TGT_NEXT];
          end
        end else if (!sub_hit) begin
          ctx_d.status = ST_NOT_FOUND;
        end else if (op_q != OP_CHECK) begin
          ctx_d.kind  = (op_q == OP_READ) ? KIND_RD_SUB : KIND_WR_SUB;
          ctx_d.idx_a = sub_idx;
          ctx_d.off   = sub_off;
        end
      end
      OP_POKE: begin
        if (!sub_hit) begin
          ctx_d.status = ST_NOT_FOUND;
        end else begin
          ctx_d.kind  = KIND_POKE;
          ctx_d.idx_a = sub_idx;
          ctx_d.off   = sub_off;
        end
      end
      default: begin
        ctx_d.status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else if (state_q == S_LOOK) begin
      ctx_q <= ctx_d;
    end
  end

  mmrs_mem #(
    .Depth (NUM_REGS),
    .Width (64)
  ) u_value_mem (
    .clk_i     (clk_i),
    .we_i      (val_we),
    .waddr_i   (val_waddr),
    .wdata_i   (val_wdata),
    .raddr_a_i (ctx_d.idx_a),
    .raddr_b_i (ctx_d.idx_b),
    .rdata_a_o (va),
    .rdata_b_o (vb)
  );

  mmrs_mem #(
    .Depth (NUM_REGS),
    .Width (64)
  ) u_mask_mem (
    .clk_i     (clk_i),
    .we_i      (upd_en),
    .waddr_i   (ctx_q.idx_a),
    .wdata_i   (wmask_q),
    .raddr_a_i (ctx_d.idx_a),
    .raddr_b_i (ctx_d.idx_b),
    .rdata_a_o (ma),
    .rdata_b_o (mb)
  );

  // modify
  logic [5:0]  sh;
  logic [63:0] lanes, m, v, m2;

  always_comb begin
    sh       = {ctx_q.off, 3'b000};
    lanes    = lane_bits(size_q);
    m        = '0;
    v        = '0;
    m2       = {32'b0, mb[31:0]};
    wa_en    = 1'b0;
    rdata_d  = '0;
    hi_val_d = (vb & ~m2) | ({32'b0, data_q[63:32]} & m2);
    case (ctx_q.kind)
      KIND_DEFINE: begin
        wa_en = 1'b1;
        m     = '1;
      end
      KIND_RD_DW: begin
        rdata_d = va | (ctx_q.b_ok ? {vb[31:0], 32'b0} : 64'b0);
      end
      KIND_WR_DW: begin
        wa_en = 1'b1;
        m     = ctx_q.a_word ? {32'b0, ma[31:0]} : ma;
        v     = data_q;
      end
      KIND_RD_SUB: begin
        rdata_d = (va >> sh) & lanes;
      end
      KIND_WR_SUB: begin
        wa_en = 1'b1;
        m     = (lanes << sh) & ma;
        v     = (data_q & lanes) << sh;
      end
      KIND_POKE: begin
        wa_en = 1'b1;
        m     = 64'hff << sh;
        v     = {56'b0, data_q[7:0]} << sh;
      end
      default: begin
        wa_en = 1'b0;
      end
    endcase
    new_a = (va & ~m) | (v & m);
  end

  assign upd_en    = (state_q == S_EXEC) && (ctx_q.kind == KIND_DEFINE);
  assign val_we    = ((state_q == S_EXEC) && wa_en) || (state_q == S_HIGH);
  assign val_waddr = (state_q == S_HIGH) ? ctx_q.idx_b : ctx_q.idx_a;
  assign val_wdata = (state_q == S_HIGH) ? hi_val_q : new_a;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      hi_val_q <= hi_val_d;
      status_q <= ctx_q.status;
      rdata_q  <= rdata_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (need_high) begin
          state_d = S_HIGH;
        end else if (accept) begin
          state_d = S_LOOK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_HIGH: begin
        state_d = accept ? S_LOOK : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == S_EXEC);
    end
  end

  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;
  assign read_data_o    = rdata_q;

`ifndef SYNTHESIS
  a_exec_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> result_valid_o)
    else $error("execute cycle not followed by a result");

  a_result_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == S_EXEC))
    else $error("result without an execute cycle");

  a_high_only_for_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HIGH) |-> $past((state_q == S_EXEC) && need_high))
    else $error("upper write without a doubleword write to a word pair");

  a_accept_starts_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_LOOK))
    else $error("accepted item did not enter lookup");
`endif

endmodule

`default_nettype wire
